/* design/ilr_pkg.sv */
package ilr_pkg;

	// Storage geometry
	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int WORD_W = 32;
	localparam int CMD_W  = 2;
	localparam int POS_W  = 7;
	localparam int LEN_W  = 7;
	localparam int ST_W   = 2;
	localparam int CAP_W  = 7;

	// Common compare width for position, count and capacity
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Read gather: cells per first-level OR group
	localparam int GRP    = 8;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CMP_W-1:0]  cmp_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Broadcast to every cell; ins/rem/rd are set only for a command that succeeds
	typedef struct packed {
		logic  ins;
		logic  rem;
		logic  rd;
		cmp_t  pos;
		word_t data;
	} cell_ctrl_t;

endpackage

/* design/ilr_req_if.sv */
interface ilr_req_if;
	logic                           valid;
	logic                           ready;
	logic [ilr_pkg::CMD_W-1:0]      cmd;
	logic [ilr_pkg::POS_W-1:0]      position;
	logic signed [ilr_pkg::WORD_W-1:0] element_data;

	modport source(output valid, output cmd, output position, output element_data,
		input ready);
	modport sink(input valid, input cmd, input position, input element_data,
		output ready);
endinterface

/* design/ilr_rsp_if.sv */
interface ilr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ilr_pkg::ST_W-1:0]       status;
	logic signed [ilr_pkg::WORD_W-1:0] read_data;
	logic [ilr_pkg::LEN_W-1:0]      length;
	logic                           full_res;

	modport source(output valid, output status, output read_data, output length,
		output full_res, input ready);
	modport sink(input valid, input status, input read_data, input length,
		input full_res, output ready);
endinterface

/* design/ilr_cfg_if.sv */
interface ilr_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ilr_pkg::CAP_W-1:0]  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/indexed_list_insert_remove_top.sv */
// Channel   Role   Carries
// req_in    sink   cmd, position, element_data
// rsp_out   source status, read_data, length, full_res
// cfg       sink   capacity (7 bits), always ready
//
// One request at a time: accept, one gather stage, then the result register.
// The two-level OR gather brings the addressed cell's word to the output; a new
// request is not accepted before the result of the last one is taken.
// All cells shift in parallel at the accept edge.
// arst_n clears the count, the pipeline valids and sets capacity to 64.
// A stalled result holds and req_in.ready stays low until it is taken.
module indexed_list_insert_remove_top (
	input  logic      clk,
	input  logic      arst_n,
	ilr_req_if.sink   req_in,
	ilr_rsp_if.source rsp_out,
	ilr_cfg_if.sink   cfg
);

	logic                      busy_q;
	logic                      v_s1;
	logic                      out_v_q;
	logic [ilr_pkg::CAP_W-1:0] cap_q;
	ilr_pkg::cnt_t             cnt_q;
	ilr_pkg::cnt_t             cnt_nx;
	ilr_pkg::cmp_t             pos_c;
	ilr_pkg::cmp_t             cnt_c;
	ilr_pkg::cmp_t             cnt_nx_c;
	ilr_pkg::cmp_t             cap_c;
	ilr_pkg::cmp_t             eff_cap;
	logic                      full_now;
	logic                      accept;
	logic                      out_take;
	ilr_pkg::status_t          status_c;
	ilr_pkg::cell_ctrl_t       ctrl;
	ilr_pkg::status_t          status_s1;
	ilr_pkg::len_t             len_s1;
	logic                      full_s1;
	ilr_pkg::status_t          status_q;
	ilr_pkg::len_t             len_q;
	logic                      full_q;
	ilr_pkg::word_t            ent  [ilr_pkg::DEPTH];
	ilr_pkg::word_t            taps [ilr_pkg::DEPTH];
	ilr_pkg::word_t            rd_word;

	assign accept   = req_in.valid && req_in.ready;
	assign out_take = rsp_out.valid && rsp_out.ready;
	assign req_in.ready = !busy_q;
	assign cfg.ready    = 1'b1;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ilr_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.data;
		end
	end

	// Effective capacity saturates at the storage depth
	assign pos_c   = ilr_pkg::cmp_t'(req_in.position);
	assign cnt_c   = ilr_pkg::cmp_t'(cnt_q);
	assign cap_c   = ilr_pkg::cmp_t'(cap_q);
	assign eff_cap = (cap_c > ilr_pkg::cmp_t'(ilr_pkg::DEPTH))
		? ilr_pkg::cmp_t'(ilr_pkg::DEPTH) : cap_c;
	assign full_now = (cnt_c >= eff_cap);

	// Command decode: status, new count and the cell broadcast
	always_comb begin
		status_c  = ilr_pkg::ST_RANGE;
		cnt_nx    = cnt_q;
		ctrl.ins  = 1'b0;
		ctrl.rem  = 1'b0;
		ctrl.rd   = 1'b0;
		ctrl.pos  = pos_c;
		ctrl.data = ilr_pkg::word_t'(req_in.element_data);
		case (req_in.cmd)
			ilr_pkg::CMD_INSERT: begin
				if (full_now) begin
					status_c = ilr_pkg::ST_FULL;
				end else if (pos_c <= cnt_c) begin
					status_c = ilr_pkg::ST_DONE;
					cnt_nx   = cnt_q + 1'b1;
					ctrl.ins = accept;
				end
			end
			ilr_pkg::CMD_REMOVE: begin
				if (pos_c < cnt_c) begin
					status_c = ilr_pkg::ST_DONE;
					cnt_nx   = cnt_q - 1'b1;
					ctrl.rem = accept;
				end
			end
			ilr_pkg::CMD_READ: begin
				if (pos_c < cnt_c) begin
					status_c = ilr_pkg::ST_DONE;
					ctrl.rd  = accept;
				end
			end
			default: begin
				status_c = ilr_pkg::ST_RANGE;
			end
		endcase
	end

	assign cnt_nx_c = ilr_pkg::cmp_t'(cnt_nx);

	// Count and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_nx;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_take) begin
				busy_q <= 1'b0;
			end
			v_s1 <= accept;
			if (v_s1) begin
				out_v_q <= 1'b1;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			len_s1    <= ilr_pkg::len_t'(cnt_nx);
			full_s1   <= (cnt_nx_c >= eff_cap);
		end
		if (v_s1) begin
			status_q <= status_s1;
			len_q    <= len_s1;
			full_q   <= full_s1;
		end
	end

	// Row of cells, each linked to its neighbors on both sides (zero beyond the ends)
	for (genvar i = 0; i < ilr_pkg::DEPTH; i++) begin : g_cell
		ilr_pkg::word_t lower_w;
		ilr_pkg::word_t upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_mid_lo
			assign lower_w = ent[i-1];
		end
		if (i == ilr_pkg::DEPTH - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_mid_hi
			assign upper_w = ent[i+1];
		end
		ilr_cell u_cell (
			.clk   (clk),
			.idx   (ilr_pkg::idx_t'(i)),
			.ctrl  (ctrl),
			.lower (lower_w),
			.upper (upper_w),
			.entry (ent[i]),
			.tap   (taps[i])
		);
	end

	ilr_gather u_gather (
		.clk     (clk),
		.en_s1   (accept),
		.en_s2   (v_s1),
		.taps    (taps),
		.word_s2 (rd_word)
	);

	assign rsp_out.valid     = out_v_q;
	assign rsp_out.status    = status_q;
	assign rsp_out.read_data = rd_word;
	assign rsp_out.length    = len_q;
	assign rsp_out.full_res  = full_q;

	// A result is only pending while a request is in flight
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> busy_q)
		else $error("result valid without a request in flight");

	// Count never exceeds storage depth
	a_cnt_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_c <= ilr_pkg::cmp_t'(ilr_pkg::DEPTH))
		else $error("count above depth");

	// A successful insert grows the list by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow count");

	// A successful remove shrinks the list by one
	a_rem_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("remove did not shrink count");

	// Gather stage always hands over to the result register
	a_s1_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> out_v_q)
		else $error("gather stage lost its result");

endmodule

/* design/ilr_cell.sv */
module ilr_cell (
	input  logic                clk,
	input  ilr_pkg::idx_t       idx,
	input  ilr_pkg::cell_ctrl_t ctrl,
	input  ilr_pkg::word_t      lower,
	input  ilr_pkg::word_t      upper,
	output ilr_pkg::word_t      entry,
	output ilr_pkg::word_t      tap
);

	ilr_pkg::word_t entry_q;
	ilr_pkg::cmp_t  my_idx;
	logic           at_pos;
	logic           above_pos;

	assign my_idx    = ilr_pkg::cmp_t'(idx);
	assign at_pos    = (my_idx == ctrl.pos);
	assign above_pos = (my_idx > ctrl.pos);

	// Insert pulls from the lower neighbor, remove from the upper one
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_pos) begin
				entry_q <= ctrl.data;
			end else if (above_pos) begin
				entry_q <= lower;
			end
		end else if (ctrl.rem) begin
			if (at_pos || above_pos) begin
				entry_q <= upper;
			end
		end
	end

	assign entry = entry_q;
	// Only the addressed cell drives the read gather
	assign tap   = (ctrl.rd && at_pos) ? entry_q : '0;

endmodule

/* design/ilr_gather.sv */
module ilr_gather (
	input  logic           clk,
	input  logic           en_s1,
	input  logic           en_s2,
	input  ilr_pkg::word_t taps [ilr_pkg::DEPTH],
	output ilr_pkg::word_t word_s2
);

	ilr_pkg::word_t grp_s1 [ilr_pkg::NGRP];
	ilr_pkg::word_t grp_or [ilr_pkg::NGRP];
	ilr_pkg::word_t all_or;
	ilr_pkg::word_t word_q;

	// First level: OR inside each group of cells
	always_comb begin
		for (int g = 0; g < ilr_pkg::NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < ilr_pkg::GRP; k++) begin
				if (g * ilr_pkg::GRP + k < ilr_pkg::DEPTH) begin
					grp_or[g] = grp_or[g] | taps[g * ilr_pkg::GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			grp_s1 <= grp_or;
		end
	end

	// Second level: OR across groups
	always_comb begin
		all_or = '0;
		for (int g = 0; g < ilr_pkg::NGRP; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			word_q <= all_or;
		end
	end

	assign word_s2 = word_q;

endmodule

/* test/ilr_list_checker.sv */
module ilr_list_checker
	import ilr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ilr_req_if   req,
	ilr_rsp_if   rsp,
	ilr_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   list_len
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHOW_MAX = 10;

	typedef struct packed {
		logic [ST_W-1:0] status;
		word_t           read_data;
		len_t            length;
		logic            full;
	} list_rsp_t;

	// Shadow copy of the list and its capacity register
	list_rsp_t   expected_q [$];
	word_t       slots [DEPTH];
	int unsigned len_now;
	int unsigned cap_now;
	list_rsp_t   got;
	list_rsp_t   want;

	// Capacity saturates at the storage depth
	function automatic logic list_is_full();
		int unsigned lim;
		lim = (cap_now > DEPTH) ? DEPTH : cap_now;
		return len_now >= lim;
	endfunction

	// Apply one request to the shadow list and build its result
	function automatic list_rsp_t list_apply(input logic [CMD_W-1:0] op,
		input logic [POS_W-1:0] at, input word_t word);
		list_rsp_t   r;
		int unsigned p;
		int unsigned i;
		r.status    = ST_RANGE;
		r.read_data = '0;
		p           = 32'(at);
		case (op)
			CMD_INSERT: begin
				// full wins over a bad position
				if (list_is_full()) begin
					r.status = ST_FULL;
				end else if (p <= len_now) begin
					for (i = len_now; i > p; i--)
						slots[i] = slots[i - 1];
					slots[p] = word;
					len_now++;
					r.status = ST_DONE;
				end
			end
			CMD_REMOVE: begin
				if (p < len_now) begin
					for (i = p; i + 1 < len_now; i++)
						slots[i] = slots[i + 1];
					len_now--;
					r.status = ST_DONE;
				end
			end
			CMD_READ: begin
				if (p < len_now) begin
					r.read_data = slots[p];
					r.status    = ST_DONE;
				end
			end
			default: ;
		endcase
		r.length = len_now[LEN_W-1:0];
		r.full   = list_is_full();
		return r;
	endfunction

	// Watch all three channels; check results against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			checked    = 0;
			len_now    = 0;
			cap_now    = 32'(CAP_RESET);
			expected_q.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				cap_now = 32'(cfg.data);
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.read_data, rsp.length, rsp.full_res};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_MAX)
						$display({"%t: unexpected result status %0d read_data %h",
							" length %0d full %0d"},
							$realtime, got.status, got.read_data, got.length, got.full);
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= SHOW_MAX)
							$display({"%t: mismatch (exp/act) status %0d/%0d",
								" read_data %h/%h length %0d/%0d full %0d/%0d"},
								$realtime, want.status, got.status,
								want.read_data, got.read_data,
								want.length, got.length, want.full, got.full);
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(list_apply(req.cmd, req.position, req.element_data));
		end
		pending  = expected_q.size();
		list_len = len_now;
	end

endmodule

/* test/indexed_list_insert_remove_top_tb.sv */
module indexed_list_insert_remove_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ilr_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 4;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 10;
	localparam int NUM_PHASES = 10;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Per phase: capacity, request count, share of inserts in percent
	localparam int PHASE_CAP [NUM_PHASES] = '{64, 127, 20, 1, 0, 64, 2, 100, 37, 64};
	localparam int PHASE_REQS [NUM_PHASES] = '{60, 110, 50, 40, 25, 70, 40, 90, 60, 55};
	localparam int PHASE_INS [NUM_PHASES] = '{70, 85, 15, 45, 40, 75, 45, 70, 45, 20};

	logic clk = 1'b0;
	logic arst_n;

	int  fail_count;
	int  pending;
	int  checked;
	int  list_len;
	bit  quiet = 1'b1;
	int  sent [4] = '{default: 0};
	int  cap_writes = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;

	ilr_req_if req_if ();
	ilr_rsp_if rsp_if ();
	ilr_cfg_if cfg_if ();

	indexed_list_insert_remove_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_in  (req_if),
		.rsp_out (rsp_if),
		.cfg     (cfg_if)
	);

	ilr_list_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.list_len   (list_len)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Gap length: mostly none, some short, a few long
	function automatic int pause_len(input int zero_pct);
		int r;
		r = $urandom_range(99);
		if (r < zero_pct)
			return 0;
		if (r < 97)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side back-pressure
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !quiet)
				stall_left = pause_len(85);
			rsp_if.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Stall watchdog: no handshake on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready)
			|| (rsp_if.valid && rsp_if.ready)
			|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("indexed_list_insert_remove_top test failed");
			$finish;
		end
	end

	// One request; valid stays high afterwards until the next negedge drive
	task automatic send(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] at,
		input word_t word);
		int n;
		n = quiet ? 0 : pause_len(60);
		repeat (n) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid        <= 1'b1;
		req_if.cmd          <= op;
		req_if.position     <= at;
		req_if.element_data <= word;
		do @(posedge clk); while (!req_if.ready);
		sent[op]++;
	endtask

	// Hold off requests until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= cap;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		cap_writes++;
	endtask

	// Mostly in-range commands against the current length, some noise
	task automatic random_item(input int ins_pct);
		int                r;
		int                len;
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  at;
		word_t             word;
		len  = list_len;
		word = $urandom;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: word = 32'h7fff_ffff;
				1: word = 32'h8000_0000;
				2: word = '0;
				default: word = '1;
			endcase
		end
		r = $urandom_range(99);
		if (r < 8) begin
			op = CMD_W'($urandom_range(3));
			at = POS_W'($urandom_range(127));
		end else begin
			r = $urandom_range(99);
			if (r < ins_pct) begin
				op = CMD_INSERT;
				at = POS_W'($urandom_range(len));
			end else begin
				op = (r < ins_pct + (100 - ins_pct) * 3 / 5) ? CMD_REMOVE : CMD_READ;
				at = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
			end
		end
		send(op, at, word);
	endtask

	initial begin
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.cmd          = CMD_INSERT;
		req_if.position     = '0;
		req_if.element_data = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.data         = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty list: everything but an insert at the head is out of range
		send(CMD_READ, 0, 32'd0);
		send(CMD_REMOVE, 0, 32'd0);
		send(CMD_UNUSED, 0, 32'd0);
		send(CMD_INSERT, 1, 32'd5);
		// Insert at head, middle and tail with extreme words
		send(CMD_INSERT, 0, 32'h7fff_ffff);
		send(CMD_INSERT, 0, 32'h8000_0000);
		send(CMD_INSERT, 2, 32'hffff_ffff);
		send(CMD_INSERT, 1, 32'd0);
		for (int i = 0; i < 4; i++)
			send(CMD_READ, POS_W'(i), 32'd0);
		send(CMD_INSERT, 127, 32'h1234_5678);
		send(CMD_READ, 4, 32'd0);
		send(CMD_READ, 127, 32'd0);
		send(CMD_REMOVE, 1, 32'hdead_beef);
		send(CMD_READ, 1, 32'd0);
		send(CMD_REMOVE, 64, 32'd0);
		send(CMD_UNUSED, 127, '1);
		// Zero capacity: always full, entries kept
		set_capacity(0);
		send(CMD_INSERT, 0, 32'd1);
		send(CMD_READ, 0, 32'd0);
		// Capacity below length: full until removes catch up
		set_capacity(2);
		send(CMD_INSERT, 100, 32'd9);
		send(CMD_REMOVE, 0, 32'd0);
		send(CMD_REMOVE, 0, 32'd0);
		send(CMD_INSERT, 1, 32'h5555_aaaa);
		quiet = 1'b0;

		// Random phases over a spread of capacities
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_capacity(CAP_W'(PHASE_CAP[ph]));
			quiet = (ph == 3 || ph == 6);
			repeat (PHASE_REQS[ph]) begin
				if ($urandom_range(49) == 0)
					drain();
				random_item(PHASE_INS[ph]);
			end
		end
		quiet = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d requests: %0d insert, %0d remove, %0d read, %0d unused command",
			sent[0] + sent[1] + sent[2] + sent[3], sent[0], sent[1], sent[2], sent[3]);
		$display("%0d results checked across %0d capacity writes (0 to 127), %s",
			checked, cap_writes, "gaps on both sides");
		if (fail_count == 0) begin
			$display("indexed_list_insert_remove_top test passed");
		end else begin
			$display("indexed_list_insert_remove_top test failed");
		end
		$finish;
	end

endmodule
